// ===== sv/bfim_pkg.sv =====
// Shared types, widths and codes for the banked frame index map.
package bfim_pkg;

  localparam int DEF_BANKS      = 4;
  localparam int DEF_PAGE_SHIFT = 12;

  localparam int MODE_W    = 2;
  localparam int SEL_W     = 2;
  localparam int BYTE_W    = 32;
  localparam int FRAME_W   = 20;
  localparam int COUNT_W   = 21;
  localparam int VALUE_W   = 23;
  localparam int BCNT_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TRANS = 2'd1,
    MODE_NEXT  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANK_COUNT   = 1'b0,
    CFG_KERNEL_BYTES = 1'b1
  } cfg_reg_t;

  // Datapath commands issued by the sequencer, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_LOAD_ADJ,
    CMD_LOAD_WRITE,
    CMD_SUM_ADD,
    CMD_SUM_DONE,
    CMD_TRANS_SKIP,
    CMD_TRANS_HIT,
    CMD_NEXT_START,
    CMD_NEXT_EXHAUST,
    CMD_NEXT_POINT,
    CMD_NEXT_ENTER,
    CMD_NEXT_ADVANCE,
    CMD_SCAN_SKIP,
    CMD_SCAN_ENTER,
    CMD_PUBLISH
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic count_zero;
    logic walk_exhausted;
    logic walk_started;
    logic walk_out;
    logic walk_end;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/bfim_if.sv =====
// Handshake channels: request words, response words and register writes.
interface bfim_req_if import bfim_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [SEL_W-1:0]     bank_sel;
  logic [BYTE_W-1:0]    bank_address;
  logic [BYTE_W-1:0]    bank_bytes;
  logic [FRAME_W-1:0]   frame_number;

  modport source (output valid, mode, bank_sel, bank_address, bank_bytes, frame_number,
                  input ready);
  modport sink   (input valid, mode, bank_sel, bank_address, bank_bytes, frame_number,
                  output ready);
endinterface

interface bfim_rsp_if import bfim_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               invalid;

  modport source (output valid, value, invalid, input ready);
  modport sink   (input valid, value, invalid, output ready);
endinterface

interface bfim_cfg_if import bfim_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bfim_ctrl.sv =====
// Sequencer: steps one request word through load, translate or enumerate.
module bfim_ctrl import bfim_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [MODE_W-1:0] req_mode,
  output logic              req_ready,
  input  stat_t             st,
  output cmd_t              op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADJ,
    S_WRITE,
    S_SUM,
    S_TRANS,
    S_NDEC,
    S_NCHK,
    S_NSCAN,
    S_PUB
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    op         = CMD_NONE;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op = CMD_CAPTURE;
          unique case (req_mode)
            MODE_LOAD:  state_next = S_ADJ;
            MODE_TRANS: state_next = S_TRANS;
            MODE_NEXT:  state_next = S_NDEC;
            default:    state_next = S_PUB;
          endcase
        end
      end
      S_ADJ: begin
        op         = CMD_LOAD_ADJ;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        op         = CMD_LOAD_WRITE;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (st.scan_done) begin
          op         = CMD_SUM_DONE;
          state_next = S_PUB;
        end else begin
          op = CMD_SUM_ADD;
        end
      end
      S_TRANS: begin
        // past the last bank the result stays invalid from capture
        if (st.scan_done) begin
          state_next = S_PUB;
        end else if (st.hit) begin
          op         = CMD_TRANS_HIT;
          state_next = S_PUB;
        end else begin
          op = CMD_TRANS_SKIP;
        end
      end
      S_NDEC: begin
        if (st.walk_exhausted) begin
          state_next = S_PUB;
        end else if (!st.walk_started) begin
          op         = CMD_NEXT_START;
          state_next = S_NSCAN;
        end else if (st.walk_out) begin
          op         = CMD_NEXT_EXHAUST;
          state_next = S_PUB;
        end else begin
          op         = CMD_NEXT_POINT;
          state_next = S_NCHK;
        end
      end
      S_NCHK: begin
        if (st.walk_end) begin
          op         = CMD_NEXT_ENTER;
          state_next = S_NSCAN;
        end else begin
          op         = CMD_NEXT_ADVANCE;
          state_next = S_PUB;
        end
      end
      S_NSCAN: begin
        if (st.scan_done) begin
          op         = CMD_NEXT_EXHAUST;
          state_next = S_PUB;
        end else if (st.count_zero) begin
          op = CMD_SCAN_SKIP;
        end else begin
          op         = CMD_SCAN_ENTER;
          state_next = S_PUB;
        end
      end
      S_PUB: begin
        // hold the result until the output register frees up
        if (st.out_free) begin
          op         = CMD_PUBLISH;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != S_IDLE))
    else $error("sequencer stayed idle after taking a request word");

  a_publish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (op == CMD_PUBLISH) |-> st.out_free)
    else $error("result published over a waiting response word");

  a_step_within_banks: assert property (@(posedge clk) disable iff (rst)
    (op == CMD_SUM_ADD || op == CMD_TRANS_SKIP || op == CMD_SCAN_SKIP) |-> !st.scan_done)
    else $error("bank walk stepped past the last active bank");
`endif

endmodule

// ===== sv/bfim_dp.sv =====
// Datapath: bank table, walk state, config registers and response register.
module bfim_dp import bfim_pkg::*; #(
  parameter int BANKS      = DEF_BANKS,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 op,
  output stat_t                st,
  input  logic [SEL_W-1:0]     bank_sel,
  input  logic [BYTE_W-1:0]    bank_address,
  input  logic [BYTE_W-1:0]    bank_bytes,
  input  logic [FRAME_W-1:0]   frame_number,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output logic                 cfg_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VALUE_W-1:0]   out_value,
  output logic                 out_invalid
);

  localparam int BW  = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int PW  = $clog2(BANKS + 1);
  localparam int AW  = (PAGE_SHIFT + FRAME_W > BYTE_W + 2) ? PAGE_SHIFT + FRAME_W : BYTE_W + 2;
  localparam int LW  = COUNT_W + 1;
  // sum of all bank counts, with room to detect saturation
  localparam int SW  = (COUNT_W + PW > VALUE_W + 1) ? COUNT_W + PW : VALUE_W + 1;
  localparam logic [PAGE_SHIFT:0] PAGE = {1'b1, {PAGE_SHIFT{1'b0}}};

  // configuration
  logic [BCNT_W-1:0] bank_count;
  logic [BYTE_W-1:0] kernel_bytes;

  // bank table
  logic [FRAME_W-1:0] bank_first_frame [BANKS];
  logic [COUNT_W-1:0] bank_frame_count [BANKS];

  // enumerator
  logic [BW-1:0]      walk_bank;
  logic [FRAME_W-1:0] walk_frame;
  logic               walk_started;
  logic               walk_exhausted;

  // captured word and work registers
  logic [SEL_W-1:0]   sel_q;
  logic [BYTE_W:0]    addr_q;
  logic [BYTE_W-1:0]  size_q;
  logic [FRAME_W-1:0] frame_q;
  logic [PW-1:0]      ptr;
  logic [SW-1:0]      acc;
  logic [VALUE_W-1:0] res_value;
  logic               res_invalid;

  logic [PW-1:0]         nb;
  logic [BW-1:0]         ridx;
  logic                  rd_ok;
  logic [FRAME_W-1:0]    rd_first;
  logic [COUNT_W-1:0]    rd_cnt;
  logic [SW-1:0]         hit_index;
  logic [FRAME_W-1:0]    walk_off;
  logic [FRAME_W-1:0]    walk_inc;
  logic [BYTE_W-1:0]     kern_add;
  logic [BYTE_W-1:0]     adj_size;
  logic [PAGE_SHIFT-1:0] rem;
  logic [PAGE_SHIFT:0]   radd;
  logic [AW-1:0]         addr_r;
  logic [BYTE_W-1:0]     size_r;
  logic [BYTE_W-1:0]     size_pg;
  logic [FRAME_W-1:0]    new_first;
  logic [COUNT_W-1:0]    new_cnt;
  logic                  sel_ok;
  logic [BW-1:0]         widx;

  always_comb begin
    if (32'(bank_count) < BANKS) begin
      nb = PW'(bank_count);
    end else begin
      nb = PW'(BANKS);
    end
  end

  // single read port on the bank table, addressed by the walk pointer
  assign ridx     = ptr[BW-1:0];
  assign rd_ok    = ptr < PW'(BANKS);
  assign rd_first = rd_ok ? bank_first_frame[ridx] : '0;
  assign rd_cnt   = rd_ok ? bank_frame_count[ridx] : '0;

  assign hit_index = acc + SW'(frame_q - rd_first);
  assign walk_off  = walk_frame - rd_first;
  assign walk_inc  = walk_frame + FRAME_W'(1);

  // load: kernel reservation on bank zero
  assign kern_add = (sel_q == '0) ? kernel_bytes : '0;
  assign adj_size = (size_q >= kern_add) ? size_q - kern_add : '0;

  // load: page rounding of the adjusted bank
  assign rem       = addr_q[PAGE_SHIFT-1:0];
  assign radd      = (rem == '0) ? '0 : PAGE - (PAGE_SHIFT + 1)'(rem);
  assign addr_r    = AW'(addr_q) + AW'(radd);
  assign size_r    = (size_q >= BYTE_W'(radd)) ? size_q - BYTE_W'(radd) : '0;
  assign size_pg   = size_r >> PAGE_SHIFT;
  assign new_first = addr_r[PAGE_SHIFT +: FRAME_W];
  assign new_cnt   = (size_pg > BYTE_W'(COUNT_MAX)) ? COUNT_MAX : size_pg[COUNT_W-1:0];
  assign sel_ok    = 32'(sel_q) < BANKS;
  assign widx      = BW'(sel_q);

  always_comb begin
    st.scan_done      = ptr >= nb;
    st.hit            = (frame_q >= rd_first) &&
                        (LW'(frame_q) < LW'(rd_first) + LW'(rd_cnt));
    st.count_zero     = rd_cnt == '0;
    st.walk_exhausted = walk_exhausted;
    st.walk_started   = walk_started;
    st.walk_out       = PW'(walk_bank) >= nb;
    st.walk_end       = (COUNT_W'(walk_off) + COUNT_W'(1)) >= rd_cnt;
    st.out_free       = !out_valid || out_ready;
  end

  assign cfg_ready = 1'b1;

  // control state: config, bank table, enumerator, walk pointer, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_count     <= BCNT_W'(1);
      kernel_bytes   <= '0;
      for (int i = 0; i < BANKS; i++) begin
        bank_first_frame[i] <= '0;
        bank_frame_count[i] <= '0;
      end
      walk_bank      <= '0;
      walk_frame     <= '0;
      walk_started   <= 1'b0;
      walk_exhausted <= 1'b0;
      ptr            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BANK_COUNT:   bank_count   <= cfg_data[BCNT_W-1:0];
          CFG_KERNEL_BYTES: kernel_bytes <= cfg_data;
        endcase
      end
      if (op == CMD_LOAD_WRITE && sel_ok) begin
        bank_first_frame[widx] <= new_first;
        bank_frame_count[widx] <= new_cnt;
      end
      case (op)
        CMD_CAPTURE:      ptr <= '0;
        CMD_SUM_ADD,
        CMD_TRANS_SKIP,
        CMD_SCAN_SKIP,
        CMD_NEXT_ENTER:   ptr <= ptr + PW'(1);
        CMD_NEXT_POINT:   ptr <= PW'(walk_bank);
        CMD_NEXT_START: begin
          walk_started <= 1'b1;
          ptr          <= '0;
        end
        CMD_NEXT_EXHAUST: walk_exhausted <= 1'b1;
        CMD_NEXT_ADVANCE: walk_frame     <= walk_inc;
        CMD_SCAN_ENTER: begin
          walk_bank  <= ridx;
          walk_frame <= rd_first;
        end
        default: ;
      endcase
      if (op == CMD_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: captured word, accumulator, result and response word
  always_ff @(posedge clk) begin
    case (op)
      CMD_CAPTURE: begin
        sel_q       <= bank_sel;
        addr_q      <= {1'b0, bank_address};
        size_q      <= bank_bytes;
        frame_q     <= frame_number;
        acc         <= '0;
        res_value   <= '0;
        res_invalid <= 1'b1;
      end
      CMD_LOAD_ADJ: begin
        addr_q <= addr_q + (BYTE_W + 1)'(kern_add);
        size_q <= adj_size;
      end
      CMD_SUM_ADD,
      CMD_TRANS_SKIP:   acc <= acc + SW'(rd_cnt);
      CMD_SUM_DONE: begin
        res_value   <= (acc > SW'(VALUE_MAX)) ? VALUE_MAX : acc[VALUE_W-1:0];
        res_invalid <= 1'b0;
      end
      CMD_TRANS_HIT: begin
        res_value   <= hit_index[VALUE_W-1:0];
        res_invalid <= 1'b0;
      end
      CMD_NEXT_ADVANCE: begin
        res_value   <= VALUE_W'(walk_inc);
        res_invalid <= 1'b0;
      end
      CMD_SCAN_ENTER: begin
        res_value   <= VALUE_W'(rd_first);
        res_invalid <= 1'b0;
      end
      CMD_PUBLISH: begin
        out_value   <= res_value;
        out_invalid <= res_invalid;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_exhaust_sticks: assert property (@(posedge clk) disable iff (rst)
    walk_exhausted |=> walk_exhausted)
    else $error("enumerator left the exhausted state without reset");

  a_publish_loads_word: assert property (@(posedge clk) disable iff (rst)
    (op == CMD_PUBLISH) |=> (out_valid && out_value == $past(res_value)))
    else $error("published result missing from the response word");

  a_ptr_bounded: assert property (@(posedge clk) disable iff (rst)
    ptr <= PW'(BANKS))
    else $error("bank walk pointer beyond the bank table");
`endif

endmodule

// ===== sv/banked_frame_index_map.sv =====
// Banked frame index map. Holds up to BANKS memory banks as first page frame and frame
// count, loads a bank (kernel bytes removed from bank zero, rounded to 2^PAGE_SHIFT-byte
// pages) and returns the saturated frame total, translates a frame number to its dense
// index across the active banks, or steps an enumerator over every frame of every
// nonempty bank; the invalid flag marks a frame outside all banks, an exhausted walk or
// a spare-mode request. One request word is in work at a time. The bank walk reads one
// bank a cycle through the single read port of the bank table. The response word sits in
// an output register, so a new request word is taken while the last response still waits.
// Register writes are always accepted and must only arrive while no request is in work.
module banked_frame_index_map import bfim_pkg::*; #(
  parameter int BANKS      = DEF_BANKS,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input logic         clk,
  input logic         rst,
  bfim_req_if.sink    req,
  bfim_rsp_if.source  rsp,
  bfim_cfg_if.sink    cfg
);

  cmd_t  op;
  stat_t st;

  bfim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .req_ready (req.ready),
    .st        (st),
    .op        (op)
  );

  bfim_dp #(
    .BANKS      (BANKS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .st           (st),
    .bank_sel     (req.bank_sel),
    .bank_address (req.bank_address),
    .bank_bytes   (req.bank_bytes),
    .frame_number (req.frame_number),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .cfg_ready    (cfg.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_value    (rsp.value),
    .out_invalid  (rsp.invalid)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the banked frame index map: loads, translations, enumeration.
`timescale 1ns / 1ps

module tb;
  import bfim_pkg::*;

  localparam bit [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam longint unsigned PAGE_BYTES = 64'd1 << DEF_PAGE_SHIFT;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 2 * DEF_BANKS + 8;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 200;

  class frame_map_board;
    typedef struct {
      bit [VALUE_W-1:0] value;
      bit               invalid;
      bit [MODE_W-1:0]  mode;
    } answer_t;

    answer_t          pending[$];
    bit [FRAME_W-1:0] first_frame[DEF_BANKS];
    bit [COUNT_W-1:0] frame_cnt[DEF_BANKS];
    bit [SEL_W-1:0]   walk_bank;
    bit [FRAME_W-1:0] walk_frame;
    bit               walk_on;
    bit               walk_done;
    bit [BCNT_W-1:0]  banks_used;
    bit [BYTE_W-1:0]  kernel_len;
    int errors, n_seen, n_load, n_trans, n_hit, n_next, n_walked, n_spare;

    function new();
      banks_used = 1;
    endfunction

    function int active();
      return (int'(banks_used) < DEF_BANKS) ? int'(banks_used) : DEF_BANKS;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [BYTE_W-1:0] data);
      if (idx == CFG_BANK_COUNT) banks_used = data[BCNT_W-1:0];
      else kernel_len = data;
    endfunction

    function void load_bank_entry(bit [SEL_W-1:0] sel, bit [BYTE_W-1:0] addr_in,
                                  bit [BYTE_W-1:0] len_in);
      longint unsigned addr, len, rem, cnt;
      if (int'(sel) >= DEF_BANKS) return;
      addr = addr_in;
      len  = len_in;
      // bank zero gives up the kernel's bytes first
      if (sel == 0) begin
        addr += kernel_len;
        len = (len >= kernel_len) ? len - kernel_len : 0;
      end
      rem = addr & (PAGE_BYTES - 1);
      if (rem != 0) begin
        rem = PAGE_BYTES - rem;
        addr += rem;
        len = (len >= rem) ? len - rem : 0;
      end
      len &= ~(PAGE_BYTES - 1);
      first_frame[sel] = FRAME_W'(addr >> DEF_PAGE_SHIFT);
      cnt = len >> DEF_PAGE_SHIFT;
      frame_cnt[sel] = (cnt > COUNT_MAX) ? COUNT_MAX : COUNT_W'(cnt);
    endfunction

    function bit [VALUE_W-1:0] frame_total();
      longint unsigned sum;
      sum = 0;
      for (int i = 0; i < active(); i++) sum += frame_cnt[i];
      return (sum > VALUE_MAX) ? VALUE_MAX : VALUE_W'(sum);
    endfunction

    function bit dense_index(bit [FRAME_W-1:0] frame, output bit [VALUE_W-1:0] idx);
      longint unsigned base;
      base = 0;
      idx  = '0;
      for (int i = 0; i < active(); i++) begin
        if (frame >= first_frame[i] &&
            longint'(frame) < longint'(first_frame[i]) + frame_cnt[i]) begin
          idx = VALUE_W'(base + (frame - first_frame[i]));
          return 1;
        end
        base += frame_cnt[i];
      end
      return 0;
    endfunction

    function bit nonempty_from(int b);
      for (int i = b; i < active(); i++)
        if (frame_cnt[i] != 0) return 1;
      return 0;
    endfunction

    function void enter_bank(int b);
      while (b < active() && frame_cnt[b] == 0) b++;
      if (b >= active()) begin
        walk_done = 1;
        return;
      end
      walk_bank  = SEL_W'(b);
      walk_frame = first_frame[b];
    endfunction

    function bit step_walk(output bit [FRAME_W-1:0] f);
      bit [FRAME_W-1:0] off;
      f = '0;
      if (walk_done) return 0;
      if (!walk_on) begin
        walk_on = 1;
        enter_bank(0);
      end else if (int'(walk_bank) >= active()) begin
        walk_done = 1;
      end else begin
        off = walk_frame - first_frame[walk_bank];
        if (longint'(off) + 1 >= frame_cnt[walk_bank]) enter_bank(int'(walk_bank) + 1);
        else walk_frame = walk_frame + FRAME_W'(1);
      end
      if (walk_done) return 0;
      f = walk_frame;
      return 1;
    endfunction

    // True when the next enumerator step would run out for good.
    function bit walk_would_end();
      bit [FRAME_W-1:0] off;
      if (walk_done) return 1;
      if (!walk_on) return !nonempty_from(0);
      if (int'(walk_bank) >= active()) return 1;
      off = walk_frame - first_frame[walk_bank];
      if (longint'(off) + 1 >= frame_cnt[walk_bank]) return !nonempty_from(int'(walk_bank) + 1);
      return 0;
    endfunction

    function void note_word(bit [MODE_W-1:0] mode, bit [SEL_W-1:0] sel, bit [BYTE_W-1:0] addr,
                            bit [BYTE_W-1:0] len, bit [FRAME_W-1:0] frame);
      answer_t a;
      bit [FRAME_W-1:0] f;
      a.mode    = mode;
      a.value   = '0;
      a.invalid = 1'b1;
      case (mode)
        MODE_LOAD: begin
          load_bank_entry(sel, addr, len);
          a.value   = frame_total();
          a.invalid = 1'b0;
          n_load++;
        end
        MODE_TRANS: begin
          n_trans++;
          if (dense_index(frame, a.value)) begin
            a.invalid = 1'b0;
            n_hit++;
          end
        end
        MODE_NEXT: begin
          n_next++;
          if (step_walk(f)) begin
            a.value   = VALUE_W'(f);
            a.invalid = 1'b0;
            n_walked++;
          end
        end
        default: n_spare++;
      endcase
      pending.push_back(a);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_word(logic [VALUE_W-1:0] value, logic invalid);
      answer_t a;
      n_seen++;
      if (pending.size() == 0) begin
        report($sformatf("response word %0d arrived with nothing outstanding", n_seen));
        return;
      end
      a = pending.pop_front();
      if (value !== a.value)
        report($sformatf("word %0d mode %0d: value %0h, expected %0h",
                         n_seen, a.mode, value, a.value));
      if (invalid !== a.invalid)
        report($sformatf("word %0d mode %0d: invalid %b, expected %b",
                         n_seen, a.mode, invalid, a.invalid));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm;
  int   gap_pct;
  int   quiet;
  frame_map_board sb = new();

  bfim_req_if req();
  bfim_rsp_if rsp();
  bfim_cfg_if cfg();

  banked_frame_index_map uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready) sb.check_word(rsp.value, rsp.invalid);
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d words outstanding",
               QUIET_LIMIT, sb.pending.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Response side: long ready runs broken by stall bursts outside the calm phase.
  initial begin
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      rsp.ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (!calm) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
    end
  end

  task automatic send_word(bit [MODE_W-1:0] mode, bit [SEL_W-1:0] sel, bit [BYTE_W-1:0] addr,
                           bit [BYTE_W-1:0] len, bit [FRAME_W-1:0] frame);
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req.valid        = 1'b1;
    req.mode         = mode;
    req.bank_sel     = sel;
    req.bank_address = addr;
    req.bank_bytes   = len;
    req.frame_number = frame;
    do @(posedge clk); while (!req.ready);
    sb.note_word(mode, sel, addr, len, frame);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [BYTE_W-1:0] data);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Drain the block before touching its registers.
  task automatic set_config(bit [BCNT_W-1:0] banks, bit [BYTE_W-1:0] kbytes);
    req.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    write_reg(CFG_BANK_COUNT, BYTE_W'(banks));
    write_reg(CFG_KERNEL_BYTES, kbytes);
  endtask

  function automatic bit [BYTE_W-1:0] pick_addr();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return $urandom & ~(BYTE_W'(PAGE_BYTES) - 1);
      2:       return $urandom_range(0, 32'h0003_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [BYTE_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, BYTE_W'(PAGE_BYTES - 1));
      3, 4, 5: return ($urandom_range(1, 64) << DEF_PAGE_SHIFT) +
                      $urandom_range(0, 1) * $urandom_range(0, BYTE_W'(PAGE_BYTES - 1));
      default: return $urandom;
    endcase
  endfunction

  // Aim most lookups at bank edges and interiors; the rest land anywhere.
  function automatic bit [FRAME_W-1:0] pick_frame();
    int b;
    b = $urandom_range(0, DEF_BANKS - 1);
    case ($urandom_range(0, 7))
      0:       return sb.first_frame[b];
      1:       return FRAME_W'(sb.first_frame[b] + sb.frame_cnt[b] - 1);
      2:       return FRAME_W'(sb.first_frame[b] + sb.frame_cnt[b]);
      3:       return sb.first_frame[b] - FRAME_W'(1);
      4, 5:    return FRAME_W'(sb.first_frame[b] + $urandom_range(0, sb.frame_cnt[b]));
      default: return FRAME_W'($urandom);
    endcase
  endfunction

  task automatic run_mix(int n);
    bit [MODE_W-1:0] mode;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      mode = (r < 20) ? MODE_LOAD : (r < 62) ? MODE_TRANS : MODE_NEXT;
      // keep the enumerator alive until the closing phase
      if (mode == MODE_NEXT && sb.walk_would_end()) mode = MODE_TRANS;
      send_word(mode, SEL_W'($urandom), pick_addr(), pick_len(), pick_frame());
    end
  endtask

  initial begin
    bit [BCNT_W-1:0] phase_banks[PHASES];
    bit [BYTE_W-1:0] phase_kernel[PHASES];
    phase_banks  = '{4, 1, 2, 7, 3, 0, 4, 4};
    phase_kernel = '{32'h0, '1, $urandom, 32'h0000_1234,
                     $urandom & ~(BYTE_W'(PAGE_BYTES) - 1), 32'h0000_0800, $urandom, 32'h0};

    req.valid        = 1'b0;
    req.mode         = MODE_LOAD;
    req.bank_sel     = '0;
    req.bank_address = '0;
    req.bank_bytes   = '0;
    req.frame_number = '0;
    cfg.valid        = 1'b0;
    cfg.index        = CFG_BANK_COUNT;
    cfg.data         = '0;
    gap_pct          = 25;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty table, extreme loads, edge lookups, first walk steps, spare mode.
    send_word(MODE_TRANS, 0, 0, 0, 0);
    set_config(4, 32'h0000_1800);
    send_word(MODE_LOAD, 0, 32'h0, 32'h0, 0);
    send_word(MODE_LOAD, 1, '1, '1, '1);
    send_word(MODE_LOAD, 2, 32'h0010_0123, 32'h0000_5000, 0);
    send_word(MODE_LOAD, 3, 32'h8000_0000, 32'h0001_0000, 0);
    send_word(MODE_LOAD, 0, 32'h0, 32'h0100_0000, 0);
    send_word(MODE_TRANS, 0, 0, 0, sb.first_frame[2]);
    send_word(MODE_TRANS, 0, 0, 0, FRAME_W'(sb.first_frame[2] + sb.frame_cnt[2] - 1));
    send_word(MODE_TRANS, 0, 0, 0, FRAME_W'(sb.first_frame[3] + sb.frame_cnt[3]));
    send_word(MODE_TRANS, 0, 0, 0, '1);
    send_word(MODE_TRANS, 0, 0, 0, 0);
    repeat (4) send_word(MODE_NEXT, 0, 0, 0, 0);
    send_word(MODE_SPARE, '1, '1, '1, '1);
    set_config(0, '1);
    send_word(MODE_TRANS, 0, 0, 0, sb.first_frame[1]);
    send_word(MODE_LOAD, 2, 32'h0000_3000, 32'h0000_2000, 0);

    for (int p = 0; p < PHASES; p++) begin
      set_config(phase_banks[p], phase_kernel[p]);
      gap_pct = $urandom_range(0, 2) * 15;
      calm    = (p == PHASES - 1);
      run_mix(PHASE_WORDS);
    end

    // Closing: small banks, one empty, edge lookups, then walk the enumerator off the end.
    set_config(4, 32'h0);
    send_word(MODE_LOAD, 0, 32'h0000_2000, 32'h0000_3000, 0);
    send_word(MODE_LOAD, 1, 32'h0010_0000, 32'h0, 0);
    send_word(MODE_LOAD, 2, 32'h0040_0800, 32'h0000_2800, 0);
    send_word(MODE_LOAD, 3, 32'h0000_9000, 32'h0000_1FFF, 0);
    for (int b = 0; b < DEF_BANKS; b++) begin
      send_word(MODE_TRANS, 0, 0, 0, sb.first_frame[b]);
      send_word(MODE_TRANS, 0, 0, 0, FRAME_W'(sb.first_frame[b] + sb.frame_cnt[b] - 1));
    end
    for (int i = 0; i < 40 && !sb.walk_done; i++) send_word(MODE_NEXT, 0, 0, 0, 0);
    repeat (3) send_word(MODE_NEXT, 0, 0, 0, 0);
    set_config(0, '1);
    send_word(MODE_TRANS, 0, 0, 0, sb.first_frame[0]);
    send_word(MODE_TRANS, 0, 0, 0, sb.first_frame[2]);
    send_word(MODE_NEXT, 0, 0, 0, 0);

    req.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("run: %0d loads, %0d lookups (%0d hits), %0d enumerator steps, %0d spare-mode words",
             sb.n_load, sb.n_trans, sb.n_hit, sb.n_next, sb.n_spare);
    $display("run: enumerator yielded %0d frames, %0d responses checked over %0d register phases",
             sb.n_walked, sb.n_seen, PHASES + 4);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bfim_pkg.sv
sv/bfim_if.sv
sv/bfim_ctrl.sv
sv/bfim_dp.sv
sv/banked_frame_index_map.sv
dv/tb.sv
